### rtl/button_press_qualifier_unit_macros.svh
// Assertion macros shared by the button press qualifier RTL.
`ifndef BUTTON_PRESS_QUALIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpq assertion failed");

// Next-cycle implication, disabled during reset.
`define BPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpq assertion failed");

`endif

### rtl/bpq_pkg.sv
// Types and constants for the button press qualifier.
`timescale 1ns / 1ps
`default_nettype none
package bpq_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CSR_WIDTH-1:0]   csr_type;

   typedef enum logic [1:0] {
      PH_REL_BEFORE = 2'd0,
      PH_PRESSED    = 2'd1,
      PH_REL_AFTER  = 2'd2,
      PH_VALID      = 2'd3
   } phase_type;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_BEFORE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_AFTER  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_WINDOW    = 2'd3;

   localparam csr_type RELEASE_BEFORE_RESET = 16'd5;
   localparam csr_type PRESSED_RESET        = 16'd5;
   localparam csr_type RELEASE_AFTER_RESET  = 16'd5;
   localparam csr_type HOLD_WINDOW_RESET    = 16'd20;

   // active-low pin: pressed reads 0
   localparam logic PIN_RELEASED = 1'b1;
   localparam logic PIN_PRESSED  = 1'b0;

endpackage
`default_nettype wire

### rtl/button_press_qualifier_unit.sv
// Button press qualifier: tick/query items in, phase and press report out.
//
// Usage:
//  - req channel: one item per tick (req_tuser = 0, req_tdata[0] = pin sample,
//    active low) or per query (req_tuser = 1, pin ignored).
//  - rsp channel: exactly one item per request, in order: press_reported in
//    rsp_tdata[0], phase after the step in rsp_tdata[2:1].
//  - csr port: write-only thresholds, index 0..3, written while idle.
//  - Results are registered: an input register, then
//    the phase/counter update into the result register.
//  - Throughput is 1 item per cycle while rsp_tready holds; the only loop is
//    the phase and counter update.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more item; req_tready drops only when both
//    are full and rsp_tready is low.
//  - Reset (synchronous, active high) returns to the release-before phase
//    with both counters cleared, empties the pipeline and reloads the
//    default thresholds (5, 5, 5, 20).
`timescale 1ns / 1ps
`default_nettype none
`include "button_press_qualifier_unit_macros.svh"
module button_press_qualifier_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [bpq_pkg::REQ_DATA_W-1:0]    req_tdata,  // [0] pin_level, [7:1] zero
   input  wire logic                              req_tuser,  // [0] kind
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [bpq_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [0] press_reported,
                                                              // [2:1] phase, [7:3] zero
   input  wire logic                              csr_we,
   input  wire logic [bpq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bpq_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import bpq_pkg::*;

   // configuration
   csr_type rel_before_ff, pressed_ff, rel_after_ff, hold_ff;

   // input register
   logic     in_valid_ff;
   kind_type in_kind_ff;
   logic     in_pin_ff;

   // qualifier state
   phase_type phase_ff, phase_in;
   count_type stable_ff, stable_in;
   count_type window_ff, window_in;

   // result register
   logic      out_valid_ff;
   logic      out_report_ff, report_in;
   phase_type out_phase_ff;

   logic      advance;
   count_type threshold;
   count_type stable_step;
   logic      expected;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_before_ff <= RELEASE_BEFORE_RESET;
         pressed_ff    <= PRESSED_RESET;
         rel_after_ff  <= RELEASE_AFTER_RESET;
         hold_ff       <= HOLD_WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RELEASE_BEFORE: rel_before_ff <= csr_wdata;
            CSR_PRESSED:        pressed_ff    <= csr_wdata;
            CSR_RELEASE_AFTER:  rel_after_ff  <= csr_wdata;
            CSR_HOLD_WINDOW:    hold_ff       <= csr_wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= kind_type'(req_tuser);
         in_pin_ff  <= req_tdata[0];
      end
   end

   always_comb begin
      case (phase_ff)
         PH_REL_BEFORE: threshold = count_type'(rel_before_ff);
         PH_PRESSED:    threshold = count_type'(pressed_ff);
         default:       threshold = count_type'(rel_after_ff);
      endcase
   end

   assign expected = (phase_ff == PH_PRESSED) ? PIN_PRESSED : PIN_RELEASED;

   always_comb begin
      phase_in    = phase_ff;
      stable_in   = stable_ff;
      window_in   = window_ff;
      report_in   = 1'b0;
      stable_step = '0;
      if (in_kind_ff == KIND_QUERY) begin
         if (phase_ff == PH_VALID) begin
            report_in = 1'b1;
            phase_in  = PH_REL_BEFORE;
            window_in = '0;
         end
      end else if (phase_ff == PH_VALID) begin
         if (window_ff == count_type'(hold_ff)) begin
            phase_in  = PH_REL_BEFORE;
            window_in = '0;
         end else begin
            window_in = window_ff + count_type'(1);
         end
      end else begin
         // compare runs on the freshly updated count
         stable_step = (in_pin_ff == expected) ? stable_ff + count_type'(1) : '0;
         stable_in   = stable_step;
         if (stable_step == threshold) begin
            stable_in = '0;
            case (phase_ff)
               PH_REL_BEFORE: phase_in = PH_PRESSED;
               PH_PRESSED:    phase_in = PH_REL_AFTER;
               default:       phase_in = PH_VALID;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_REL_BEFORE;
         stable_ff <= '0;
         window_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         stable_ff <= stable_in;
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_report_ff <= report_in;
         out_phase_ff  <= phase_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, out_phase_ff, out_report_ff};

   // window counter only runs inside the valid phase
   `BPQ_ASSERT_NOW(a_window_idle, clock, reset, phase_ff != PH_VALID, window_ff == '0)
   // stable counter is cleared on entry to the valid phase and untouched there
   `BPQ_ASSERT_NOW(a_stable_clear, clock, reset, phase_ff == PH_VALID, stable_ff == '0)
   // a held input item is not dropped while the result side stalls
   `BPQ_ASSERT_NEXT(a_hold_item, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // a reported press always leaves the block in the release-before phase
   `BPQ_ASSERT_NEXT(a_query_clear, clock, reset, advance && report_in, phase_ff == PH_REL_BEFORE)

endmodule
`default_nettype wire
